@@ rtl/oale_pkg.sv @@
package oale_pkg;
  localparam int unsigned Depth     = 32;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_LOCATE = 3'd3,
    REQ_APPEND = 3'd4,
    REQ_PURGE  = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic signed [31:0] item_value;
    logic [5:0]        position;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] found_index;
    logic [5:0] entry_count;
  } rsp_t;
endpackage

@@ rtl/oale_if.sv @@
interface oale_req_if;
  import oale_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface oale_rsp_if;
  import oale_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/oale_store.sv @@
module oale_store (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [oale_pkg::IdxW-1:0]      waddr_i,
  input  logic [oale_pkg::DataWidth-1:0] wdata_i,
  input  logic [oale_pkg::IdxW-1:0]      raddr_i,
  output logic [oale_pkg::DataWidth-1:0] rdata_o
);
  import oale_pkg::*;
  logic [DataWidth-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/ordered_array_list_engine.sv @@
// Channel | Dir | Payload
// req     | in  | req_type, item_value, position
// rsp     | out | status, found_index, entry_count
// One request at a time through one single-port-read list memory and one
// comparator. Insert shifts entries up from the tail, delete shifts them down,
// locate/append scan from index 0, purge compares each entry with earlier ones.
// Reset clears count and control; memory content is undefined until written.
// req_i.ready stays low from accept until the response transfers.
module ordered_array_list_engine (
  input logic clk_i,
  input logic rst_ni,
  oale_req_if.sink   req_i,
  oale_rsp_if.source rsp_o
);
  import oale_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD, S_RW, S_SRCH_RD, S_SRCH_CMP,
    S_PG_RDI, S_PG_RDJ, S_PG_CMP, S_DONE
  } state_e;

  state_e               state_q;
  logic [2:0]           kind_q;
  logic [DataWidth-1:0] val_q, cur_q;
  logic [CntW-1:0]      pos_q, cnt_q, i_q, j_q;
  logic [2:0]           st_q;
  logic [IdxW-1:0]      fidx_q;
  logic                 we;
  logic [IdxW-1:0]      waddr, raddr;
  logic [DataWidth-1:0] wdata, rdata;

  oale_store u_store (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                      .raddr_i(raddr), .rdata_o(rdata));

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = (state_q == S_DONE);
  assign rsp_o.data.status = st_q;
  assign rsp_o.data.found_index = 5'(fidx_q);
  assign rsp_o.data.entry_count = 6'(cnt_q);

  // memory port control, by state
  always_comb begin
    we = 1'b0; waddr = '0; wdata = rdata; raddr = '0;
    unique case (state_q)
      S_RD: begin
        // insert reads i-1 going down; delete/purge-remove reads i going up
        raddr = (kind_q == REQ_INSERT) ? IdxW'(i_q - 1'b1) : IdxW'(i_q);
      end
      S_RW: begin
        we = 1'b1;
        waddr = (kind_q == REQ_INSERT) ? IdxW'(i_q) : IdxW'(i_q - 1'b1);
      end
      S_SRCH_RD: raddr = IdxW'(i_q);
      S_PG_RDI:  raddr = IdxW'(i_q);
      S_PG_RDJ:  raddr = IdxW'(j_q);
      default: ;
    endcase
    if (state_q == S_DISP && kind_q == REQ_INSERT && i_q == pos_q &&
        cnt_q < CntW'(Depth)) begin
      we = 1'b1; waddr = IdxW'(pos_q); wdata = val_q;
    end
    if (state_q == S_SRCH_CMP && kind_q == REQ_APPEND && i_q == cnt_q &&
        cnt_q < CntW'(Depth)) begin
      we = 1'b1; waddr = IdxW'(cnt_q); wdata = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; st_q <= ST_OK; fidx_q <= '0;
      kind_q <= '0; val_q <= '0; cur_q <= '0; pos_q <= '0; i_q <= '0; j_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (req_i.valid) begin
          kind_q <= req_i.data.req_type;
          val_q  <= DataWidth'(signed'(req_i.data.item_value));
          pos_q  <= CntW'(req_i.data.position);
          st_q   <= ST_OK; fidx_q <= '0;
          state_q <= S_DISP;
          // insert walks down from count; others start as set in dispatch
          i_q <= cnt_q;
        end
        S_DISP: begin
          state_q <= S_DONE;
          priority case (kind_q)
            REQ_CLEAR: cnt_q <= '0;
            REQ_INSERT: begin
              if (cnt_q >= CntW'(Depth)) st_q <= ST_FULL;
              else if (pos_q > cnt_q) st_q <= ST_BADPOS;
              else if (i_q == pos_q) cnt_q <= cnt_q + 1'b1;
              else state_q <= S_RD;
            end
            REQ_DELETE: begin
              if (cnt_q == '0) st_q <= ST_EMPTY;
              else if (pos_q >= cnt_q) st_q <= ST_BADPOS;
              else begin i_q <= pos_q + 1'b1; state_q <= S_RD; end
            end
            REQ_LOCATE, REQ_APPEND: begin i_q <= '0; state_q <= S_SRCH_RD; end
            REQ_PURGE: begin i_q <= CntW'(1); state_q <= S_PG_RDI; end
            default: ;
          endcase
        end
        S_RD: begin
          if (kind_q != REQ_INSERT && i_q >= cnt_q) begin
            cnt_q <= cnt_q - 1'b1;
            state_q <= (kind_q == REQ_PURGE) ? S_PG_RDI : S_DONE;
          end else state_q <= S_RW;
        end
        S_RW: begin
          if (kind_q == REQ_INSERT) begin
            i_q <= i_q - 1'b1;
            // pos slot gets written by dispatch when i reaches pos
            state_q <= (i_q - 1'b1 == pos_q) ? S_DISP : S_RD;
          end else begin
            i_q <= i_q + 1'b1; state_q <= S_RD;
          end
        end
        S_SRCH_RD: begin
          if (i_q >= cnt_q) begin
            state_q <= S_SRCH_CMP;
          end else state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (i_q >= cnt_q) begin
            state_q <= S_DONE;
            if (kind_q == REQ_LOCATE) st_q <= ST_NOTFOUND;
            else if (cnt_q >= CntW'(Depth)) st_q <= ST_FULL;
            else cnt_q <= cnt_q + 1'b1;
          end else if (rdata == val_q) begin
            if (kind_q == REQ_LOCATE) fidx_q <= IdxW'(i_q);
            state_q <= S_DONE;
          end else begin
            i_q <= i_q + 1'b1; state_q <= S_SRCH_RD;
          end
        end
        S_PG_RDI: begin
          if (i_q >= cnt_q) state_q <= S_DONE;
          else begin j_q <= '0; state_q <= S_PG_RDJ; end
        end
        S_PG_RDJ: begin
          if (j_q == '0) cur_q <= rdata; // data of entry i
          state_q <= S_PG_CMP;
        end
        S_PG_CMP: begin
          // j stays below i, so a match is an earlier copy of entry i
          if (rdata == cur_q) begin
            // remove entry i: shift from i+1 down
            i_q <= i_q + 1'b1; state_q <= S_RD;
            j_q <= i_q;
          end else if (j_q + 1'b1 >= i_q) begin
            i_q <= i_q + 1'b1; state_q <= S_PG_RDI;
          end else begin
            j_q <= j_q + 1'b1; state_q <= S_PG_RDJ;
          end
        end
        S_DONE: if (rsp_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      // purge removal finished: resume at the same i
      if (state_q == S_RD && kind_q == REQ_PURGE && i_q >= cnt_q) i_q <= j_q;
    end
  end
endmodule
